@@ src/magma_pkg.sv @@
// Shared types, S-box table and round functions for the Magma block cipher.
// No dependencies; imported by magma_round and magma_block_cipher.
`timescale 1ns / 1ps
`default_nettype none
package magma_pkg;

	localparam int ROUNDS    = 32;
	localparam int NUM_KEYS  = 8;
	localparam int HALF_W    = 32;
	localparam int BLOCK_W   = 2 * HALF_W;
	localparam int KEY_IDX_W = $clog2(NUM_KEYS);
	localparam int ADDR_W    = KEY_IDX_W + 2;
	localparam int ROT_AMT   = 11;
	localparam int FWD_ROUNDS = 24;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	typedef logic [HALF_W-1:0] half_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;

	typedef struct packed {
		logic valid;
		logic mode;
	} pipe_ctl_t;

	typedef logic [3:0] sbox_row_t [16];

	localparam sbox_row_t SBOX [NUM_KEYS] = '{
		'{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
		  4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
		'{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
		  4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
		'{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
		'{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
		  4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
		'{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
		  4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
		'{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
		  4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
		'{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
		  4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
		'{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
		  4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
	};

	function automatic half_t subst_word(input half_t x);
		half_t y;
		y = '0;
		for (int n = 0; n < NUM_KEYS; n++) begin
			y[4*n +: 4] = SBOX[n][x[4*n +: 4]];
		end
		return y;
	endfunction

	function automatic half_t round_fn(input half_t half, input half_t k);
		half_t s;
		s = subst_word(half + k);
		return {s[HALF_W-1-ROT_AMT:0], s[HALF_W-1:HALF_W-ROT_AMT]};
	endfunction

	function automatic key_idx_t key_index(input int r);
		key_idx_t low;
		low = key_idx_t'(r % NUM_KEYS);
		return (r < FWD_ROUNDS) ? low : key_idx_t'(NUM_KEYS - 1) - low;
	endfunction

endpackage
`default_nettype wire

@@ src/magma_block_cipher.sv @@
// Magma 64-bit block cipher: 32 round stages plus APB key registers.
// Depends on magma_pkg and magma_round.
// Each round is registered in its own stage, one round per stage.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset clears all stage valid bits and sets the eight key words to zero.
`timescale 1ns / 1ps
`default_nettype none
module magma_block_cipher
	import magma_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [HALF_W-1:0]  pwdata,
	output logic [HALF_W-1:0]       prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [BLOCK_W-1:0] block_in,
	input  wire logic               mode,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [BLOCK_W-1:0]      block_out
);

	half_t     key_q [NUM_KEYS];
	key_idx_t  reg_sel;
	logic      cfg_wr;
	logic      en;
	pipe_ctl_t ctl   [ROUNDS+1];
	half_t     a1    [ROUNDS+1];
	half_t     a0    [ROUNDS+1];

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = key_q[reg_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			key_q[reg_sel] <= pwdata;
		end
	end

	assign en        = !ctl[ROUNDS].valid || out_ready;
	assign in_ready  = en;
	assign ctl[0]    = '{valid: in_valid, mode: mode};
	assign a1[0]     = block_in[BLOCK_W-1:HALF_W];
	assign a0[0]     = block_in[HALF_W-1:0];

	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		localparam key_idx_t ENC_IDX = key_index(r);
		localparam key_idx_t DEC_IDX = key_index(ROUNDS - 1 - r);
		magma_round u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl[r]),
			.a1_in   (a1[r]),
			.a0_in   (a0[r]),
			.key_enc (key_q[ENC_IDX]),
			.key_dec (key_q[DEC_IDX]),
			.ctl_out (ctl[r+1]),
			.a1_out  (a1[r+1]),
			.a0_out  (a0[r+1])
		);
	end

	assign out_valid = ctl[ROUNDS].valid;
	assign block_out = {a0[ROUNDS], a1[ROUNDS]};

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ctl[1].valid)
		else $error("accepted item did not reach first stage");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without output stall");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl[ROUNDS/2].valid |=> ctl[ROUNDS/2+1].valid)
		else $error("item lost in mid pipeline");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(block_out) && out_valid)
		else $error("stalled result changed");

	a_key_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> key_q[$past(reg_sel)] == $past(pwdata))
		else $error("key word write lost");

endmodule
`default_nettype wire

@@ src/magma_round.sv @@
// One Feistel round of Magma as a single pipeline stage.
// Depends on magma_pkg for the round function and control struct.
`timescale 1ns / 1ps
`default_nettype none
module magma_round
	import magma_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire pipe_ctl_t ctl_in,
	input  wire half_t     a1_in,
	input  wire half_t     a0_in,
	input  wire half_t     key_enc,
	input  wire half_t     key_dec,
	output pipe_ctl_t      ctl_out,
	output half_t          a1_out,
	output half_t          a0_out
);

	pipe_ctl_t ctl_s1;
	half_t     a1_s1;
	half_t     a0_s1;
	half_t     rkey;

	assign rkey = (ctl_in.mode == MODE_DEC) ? key_dec : key_enc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1 <= a0_in;
			a0_s1 <= a1_in ^ round_fn(a0_in, rkey);
		end
	end

	assign ctl_out = ctl_s1;
	assign a1_out  = a1_s1;
	assign a0_out  = a0_s1;

endmodule
`default_nettype wire
